// ===== rtl/alu_sf_pkg.sv =====
// Package for the ALU with status flags: operation codes, flag bundle, widths.
// No dependencies; imported by every module under rtl/.
package alu_sf_pkg;

	localparam int WORD_W    = 32;
	localparam int CNT_W     = 4;
	localparam int MAX_SHIFT = 8;
	localparam int KIND_W    = 4;
	localparam int OUT_W     = 40;

	typedef enum logic [KIND_W-1:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBC = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_NOT = 4'd7,
		OP_SRL = 4'd8,
		OP_SLL = 4'd9,
		OP_SRA = 4'd10,
		OP_SLA = 4'd11,
		OP_RR  = 4'd12,
		OP_RL  = 4'd13
	} op_t;

	typedef struct packed {
		logic c;
		logic v;
		logic z;
		logic n;
	} flags_t;

endpackage

// ===== rtl/alu_sf_shift.sv =====
// Barrel shifter and rotator for counts 0 to 15 on one 32-bit word.
// Depends on alu_sf_pkg.
module alu_sf_shift (
	input  alu_sf_pkg::op_t                      kind,
	input  logic [alu_sf_pkg::WORD_W-1:0]        a,
	input  logic [alu_sf_pkg::CNT_W-1:0]         cnt,
	output logic [alu_sf_pkg::WORD_W-1:0]        res
);
	import alu_sf_pkg::*;

	logic [2*WORD_W-1:0] dbl;
	logic [2*WORD_W-1:0] rot_r;
	logic [2*WORD_W-1:0] rot_l;

	assign dbl   = {a, a};
	assign rot_r = dbl >> cnt;
	assign rot_l = dbl << cnt;

	always_comb begin
		unique case (kind)
			OP_SRL:         res = a >> cnt;
			OP_SLL, OP_SLA: res = a << cnt;
			OP_SRA:         res = $unsigned($signed(a) >>> cnt);
			OP_RR:          res = rot_r[WORD_W-1:0];
			OP_RL:          res = rot_l[2*WORD_W-1:WORD_W];
			default:        res = a;
		endcase
	end

endmodule

// ===== rtl/alu_sf_exec.sv =====
// Execute stage: arithmetic, logic and shifts with the next value of the flags.
// Depends on alu_sf_pkg and alu_sf_shift.
module alu_sf_exec (
	input  alu_sf_pkg::op_t                  kind,
	input  logic [alu_sf_pkg::WORD_W-1:0]    a,
	input  logic [alu_sf_pkg::WORD_W-1:0]    b,
	input  alu_sf_pkg::flags_t               flags_in,
	output logic [alu_sf_pkg::WORD_W-1:0]    res,
	output alu_sf_pkg::flags_t               flags_out,
	output logic                             err
);
	import alu_sf_pkg::*;

	logic              cin;
	logic [WORD_W:0]   sum;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] sh_res;
	logic              cnt_big;

	assign cin  = ((kind == OP_ADC) || (kind == OP_SBC)) ? flags_in.c : 1'b0;
	assign sum  = {1'b0, a} + {1'b0, b} + {{WORD_W{1'b0}}, cin};
	assign diff = {1'b0, a} - {1'b0, b} - {{WORD_W{1'b0}}, cin};
	// anything above the largest count, including the upper bits, is an error
	assign cnt_big = (b[WORD_W-1:CNT_W] != '0) ||
		(b[CNT_W-1:0] > CNT_W'(MAX_SHIFT));

	alu_sf_shift u_shift (
		.kind (kind),
		.a    (a),
		.cnt  (b[CNT_W-1:0]),
		.res  (sh_res)
	);

	always_comb begin
		res       = '0;
		err       = 1'b0;
		flags_out = flags_in;
		unique case (kind)
			OP_ADD, OP_ADC: begin
				res         = sum[WORD_W-1:0];
				flags_out.v = (a[WORD_W-1] == b[WORD_W-1]) &&
					(res[WORD_W-1] != a[WORD_W-1]);
				flags_out.c = sum[WORD_W];
			end
			OP_SUB, OP_SBC: begin
				res         = diff[WORD_W-1:0];
				flags_out.v = (a[WORD_W-1] != b[WORD_W-1]) &&
					(res[WORD_W-1] != a[WORD_W-1]);
				flags_out.c = diff[WORD_W];
			end
			OP_AND: res = a & b;
			OP_OR:  res = a | b;
			OP_XOR: res = a ^ b;
			OP_NOT: res = ~a;
			OP_SRL, OP_SLL, OP_SRA, OP_SLA, OP_RR, OP_RL: begin
				if (cnt_big) begin
					err = 1'b1;
				end else begin
					res = sh_res;
				end
			end
			default: res = '0;
		endcase
		// N and Z follow the result for every code that produces one
		if ((kind <= OP_RL) && !err) begin
			flags_out.n = res[WORD_W-1];
			flags_out.z = (res == '0);
		end
	end

endmodule

// ===== rtl/alu_with_status_flags_core.sv =====
// Top level of the 32-bit ALU with kept N, Z, V and C status flags.
// Depends on alu_sf_pkg and alu_sf_exec (which uses alu_sf_shift).
//
// Each transfer on the slave side carries an operation code in s_tuser and two
// operands in s_tdata; the master side returns one transfer per input with the
// result, the flags as they stand after the operation and an error bit. The
// block takes one transfer every clock cycle while the output keeps taking
// results, and passes it through the input register, after which the execute
// logic loads the output register and the status flags together. The carry
// loop from the flag register back through the adder into adc and sbc sets
// the rate of one operation per cycle. A stalled output holds the output
// register; the input register still takes a transfer while the output
// register is free or being emptied. Shift and rotate counts above eight give
// error = 1, result = 0 and leave every flag unchanged; codes 14 and 15 give
// result = 0 and leave the flags unchanged. Reset clears all flags.
module alu_with_status_flags_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] operand_a, [63:32] operand_b
	input  logic [3:0]  s_tuser,  // [3:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [31:0] result, [32] flag_n, [33] flag_z,
	                              // [34] flag_v, [35] flag_c, [36] error, [39:37] zero
);
	import alu_sf_pkg::*;

	// input register
	logic              valid_s1;
	op_t               kind_s1;
	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;

	// output register
	logic              valid_s2;
	logic [WORD_W-1:0] res_s2;
	flags_t            flg_s2;
	logic              err_s2;

	// kept status flags
	flags_t            flags_q;

	logic              adv_s2;
	logic              adv_s1;
	logic [WORD_W-1:0] ex_res;
	flags_t            ex_flags;
	logic              ex_err;

	// advance the output register when it is empty or being taken
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	// the input register frees up whenever its item moves on
	assign s_tready = !valid_s1 || adv_s2;
	assign adv_s1   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s1 <= op_t'(s_tuser);
			a_s1    <= s_tdata[WORD_W-1:0];
			b_s1    <= s_tdata[2*WORD_W-1:WORD_W];
		end
	end

	alu_sf_exec u_exec (
		.kind      (kind_s1),
		.a         (a_s1),
		.b         (b_s1),
		.flags_in  (flags_q),
		.res       (ex_res),
		.flags_out (ex_flags),
		.err       (ex_err)
	);

	// flags change exactly when an item leaves the input register, so the
	// next item in line already sees the updated carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) begin
				flags_q <= ex_flags;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= ex_res;
			flg_s2 <= ex_flags;
			err_s2 <= ex_err;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, err_s2, flg_s2.c, flg_s2.v, flg_s2.z, flg_s2.n, res_s2};

`ifndef ASSERT_OFF
	// an error result is always zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[36]) |-> (m_tdata[31:0] == '0))
		else $error("error result is not zero");

	// the flags shown on the output match the kept flags
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[35:32] == {flags_q.c, flags_q.v, flags_q.z, flags_q.n}))
		else $error("output flags differ from kept flags");

	// kept flags hold when no item is executed
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(flags_q))
		else $error("flags changed without an executed item");

	// an executed item is offered on the next cycle
	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> m_tvalid)
		else $error("executed item not offered");
`endif

endmodule

// ===== sim/alu_flags_checker.sv =====
`timescale 1ns / 1ps
// Checker for alu_with_status_flags_core: watches both stream channels, predicts
// every result from its own copy of the status flags and compares field by field.
// Depends on alu_sf_pkg for operation codes, widths and the flag bundle.
module alu_flags_checker
	import alu_sf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          fail_count,
	output int          outstanding,
	output int          checked
);

	typedef struct packed {
		logic [WORD_W-1:0] result;
		flags_t            flags;
		logic              err;
	} alu_out_t;

	flags_t   kept_flags;
	alu_out_t expected_q[$];

	function automatic logic [WORD_W-1:0] shifted_word(input logic [KIND_W-1:0] kind,
			input logic [WORD_W-1:0] a, input logic [CNT_W-1:0] n);
		logic [WORD_W-1:0] r;
		r = a;
		if (n != 0) begin
			case (kind)
				OP_SRL:         r = a >> n;
				OP_SLL, OP_SLA: r = a << n;
				OP_SRA:         r = $unsigned($signed(a) >>> n);
				OP_RR:          r = (a >> n) | (a << (WORD_W - n));
				default:        r = (a << n) | (a >> (WORD_W - n));
			endcase
		end
		return r;
	endfunction

	// One operation against the kept flags; returns the result and the new flags.
	function automatic alu_out_t alu_result_of(input logic [KIND_W-1:0] kind,
			input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b, input flags_t fl);
		alu_out_t        o;
		logic [WORD_W:0] wide;
		logic            cin;
		o.result = '0;
		o.flags  = fl;
		o.err    = 1'b0;
		cin      = (kind == OP_ADC || kind == OP_SBC) ? fl.c : 1'b0;
		case (kind)
			OP_ADD, OP_ADC: begin
				wide      = {1'b0, a} + {1'b0, b} + cin;
				o.result  = wide[WORD_W-1:0];
				o.flags.v = (a[31] == b[31]) && (o.result[31] != a[31]);
				o.flags.c = wide[WORD_W];
			end
			OP_SUB, OP_SBC: begin
				o.result  = a - b - cin;
				o.flags.v = (a[31] != b[31]) && (o.result[31] != a[31]);
				o.flags.c = ({1'b0, b} + cin) > {1'b0, a};
			end
			OP_AND: o.result = a & b;
			OP_OR:  o.result = a | b;
			OP_XOR: o.result = a ^ b;
			OP_NOT: o.result = ~a;
			OP_SRL, OP_SLL, OP_SRA, OP_SLA, OP_RR, OP_RL: begin
				// counts above the limit, wide patterns included, give an error
				if (b > MAX_SHIFT)
					o.err = 1'b1;
				else
					o.result = shifted_word(kind, a, b[CNT_W-1:0]);
			end
			default: ;
		endcase
		// spare codes and errored shifts leave N and Z alone
		if (!o.err && kind <= OP_RL) begin
			o.flags.n = o.result[31];
			o.flags.z = (o.result == '0);
		end
		return o;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		alu_out_t want;
		if (!arst_n) begin
			kept_flags = '0;
			expected_q.delete();
			fail_count  = 0;
			outstanding = 0;
			checked     = 0;
		end else begin
			// retire the oldest expectation first; a result never follows its input
			// in the same cycle
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer 0x%0h with no expectation waiting", m_tdata);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("result", want.result, m_tdata[31:0]);
					check_field("flag_n", WORD_W'(want.flags.n), WORD_W'(m_tdata[32]));
					check_field("flag_z", WORD_W'(want.flags.z), WORD_W'(m_tdata[33]));
					check_field("flag_v", WORD_W'(want.flags.v), WORD_W'(m_tdata[34]));
					check_field("flag_c", WORD_W'(want.flags.c), WORD_W'(m_tdata[35]));
					check_field("error", WORD_W'(want.err), WORD_W'(m_tdata[36]));
					check_field("padding", '0, WORD_W'(m_tdata[39:37]));
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				want       = alu_result_of(s_tuser, s_tdata[31:0], s_tdata[63:32], kept_flags);
				kept_flags = want.flags;
				expected_q.push_back(want);
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== sim/alu_with_status_flags_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for alu_with_status_flags_core: drives operations, throttles both
// sides and gives the verdict. Depends on alu_sf_pkg and alu_flags_checker.
module alu_with_status_flags_core_tb;
	import alu_sf_pkg::*;

	// Codes 14 and 15 have no operation behind them
	localparam logic [KIND_W-1:0] OP_SPARE_LO = 4'd14;
	localparam logic [KIND_W-1:0] OP_SPARE_HI = 4'd15;
	localparam int RANDOM_ITEMS = 1025;
	localparam int LONG_HOLD    = 200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [31:0] operand_a, [63:32] operand_b
	logic [3:0]  s_tuser;   // [3:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] result, [32] n, [33] z, [34] v, [35] c, [36] error

	int fail_count;
	int outstanding;
	int checked;
	int tx_mode;
	int rx_mode;
	int sent;
	int over_counts;

	alu_with_status_flags_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	alu_flags_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle cycles before the next transfer: none, light or full spread up to 16
	function automatic int idle_gap(input int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, 3);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Operand with the extremes weighted in
	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal counts; the rest just over the limit or any 32-bit pattern
	function automatic logic [WORD_W-1:0] random_count();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(9, 40);
			1:       return $urandom;
			default: return $urandom_range(0, MAX_SHIFT);
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] random_kind();
		if ($urandom_range(0, 24) == 0)
			return KIND_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		return KIND_W'($urandom_range(OP_ADD, OP_RL));
	endfunction

	// Offer one transfer after a random gap; entered and left at a falling edge.
	// Valid stays high between back-to-back transfers.
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		int gap;
		gap = idle_gap(tx_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (kind >= OP_SRL && kind <= OP_RL && b > MAX_SHIFT)
			over_counts++;
		@(negedge clk);
	endtask

	// Hold the input side until every expected result has come back
	task automatic drain_input();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// Result side: random stalls per transfer, plus two long hold-offs so that
	// the pipeline fills and back-pressures the input
	initial begin : sink
		int gap;
		int taken;
		m_tready = 1'b0;
		taken    = 0;
		rx_mode  = 2;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 48 == 0)
				rx_mode = $urandom_range(0, 2);
			if (taken == 40 || taken == 700)
				gap = LONG_HOLD;
			else
				gap = idle_gap(rx_mode);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		tx_mode     = 2;
		sent        = 0;
		over_counts = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: carry, borrow and overflow corners, the carry chain into adc
		// and sbc, every logic op, zero and full counts, rotate left to zero,
		// counts over the limit and the spare codes
		send_item(OP_ADD, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(OP_ADC, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_SUB, 32'h0000_0000, 32'h0000_0001);
		send_item(OP_SBC, 32'h0000_0005, 32'h0000_0002);
		send_item(OP_SUB, 32'h8000_0000, 32'h0000_0001);
		send_item(OP_SBC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_AND, 32'hFFFF_FFFF, 32'h8000_0000);
		send_item(OP_OR, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_XOR, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_item(OP_NOT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_NOT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_SRL, 32'h8000_0000, 32'h0000_0000);
		send_item(OP_SRL, 32'hFFFF_FFFF, 32'h0000_0008);
		send_item(OP_SLL, 32'h0000_0001, 32'h0000_0008);
		send_item(OP_SRA, 32'h8000_0000, 32'h0000_0008);
		send_item(OP_SLA, 32'h1234_5678, 32'h0000_0004);
		send_item(OP_RR, 32'h0000_0001, 32'h0000_0001);
		send_item(OP_RL, 32'h8000_0000, 32'h0000_0001);
		send_item(OP_RL, 32'h0000_0000, 32'h0000_0005);
		send_item(OP_RR, 32'h1234_5678, 32'h0000_0009);
		send_item(OP_SLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_SRA, 32'h0000_0001, 32'h8000_0000);
		send_item(OP_SPARE_LO, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(OP_SPARE_HI, 32'h0000_0001, 32'hFFFF_FFFF);
		drain_input();

		// Random: change the input pacing every 64 transfers and pause once
		// half-way until the pipeline is empty
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				tx_mode = $urandom_range(0, 2);
			if (i == RANDOM_ITEMS / 2)
				drain_input();
			kind = random_kind();
			a    = random_word();
			if (kind >= OP_SRL && kind <= OP_RL)
				b = random_count();
			else
				b = random_word();
			send_item(kind, a, b);
		end

		drain_input();
		repeat (8) @(posedge clk);
		$display("Run covered %0d operations with %0d results checked, %0d of them shifts",
			sent, checked, over_counts);
		$display("or rotates with an out-of-range count, plus two long result-side stalls.");
		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
